// File: src/bpc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the barometric pressure compensation block.
// No dependencies.
package bpc_pkg;

  localparam int UpBits      = 19;
  localparam int QueueDepth  = 4;
  localparam int DivBits     = 32;
  localparam int DsrBits     = 18;
  localparam int DivStages   = DivBits;
  localparam int BackLatency = 2 * DivStages + 17;

  localparam logic [15:0]        PressScale = 16'd50000;
  localparam logic signed [27:0] TempOffset = 28'sd4000;
  localparam logic [11:0]        PressQuad  = 12'd3038;
  localparam logic signed [14:0] PressLin   = -15'sd7357;
  localparam logic signed [47:0] PressConst = 48'sd3791;
  localparam logic [19:0]        PressMax   = 20'hFFFFF;
  localparam logic [1:0]         OssReset   = 2'd3;

  typedef enum logic [1:0] {
    REG_TEMP  = 2'd0,
    REG_PLIN  = 2'd1,
    REG_PQUAD = 2'd2,
    REG_OSS   = 2'd3
  } bpc_reg_t;

  typedef struct packed {
    logic [15:0]        ac5;
    logic [15:0]        ac6;
    logic signed [15:0] mc;
    logic signed [15:0] md;
    logic signed [15:0] ac1;
    logic signed [15:0] ac2;
    logic signed [15:0] ac3;
    logic [15:0]        ac4;
    logic signed [15:0] b1;
    logic signed [15:0] b2;
    logic [1:0]         oss;
  } bpc_cfg_t;

  typedef struct packed {
    logic [15:0]        ut;
    logic [UpBits-1:0]  up;
  } bpc_sample_t;

endpackage

// File: src/bpc_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, sample intake and raw pressure alignment.
// Depends on bpc_pkg.
module bpc_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       sample_valid,
  output logic                       sample_stall,
  input  logic [15:0]                raw_temperature,
  input  logic [23:0]                raw_pressure_bytes,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [63:0]                cfg_data,
  output bpc_pkg::bpc_cfg_t          cfg,
  output logic                       push,
  output bpc_pkg::bpc_sample_t       push_data,
  input  logic                       queue_full
);

  logic [23:0] up_shifted;

  assign cfg_ready    = 1'b1;
  assign sample_stall = queue_full;
  assign push         = sample_valid && !queue_full;

  assign up_shifted   = raw_pressure_bytes >> (4'd8 - {2'b00, cfg.oss});
  assign push_data.ut = raw_temperature;
  assign push_data.up = up_shifted[bpc_pkg::UpBits-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= bpc_pkg::bpc_cfg_t'({160'd0, bpc_pkg::OssReset});
    end else if (cfg_valid && cfg_ready) begin
      case (bpc_pkg::bpc_reg_t'(cfg_index))
        bpc_pkg::REG_TEMP: begin
          cfg.ac5 <= cfg_data[63:48];
          cfg.ac6 <= cfg_data[47:32];
          cfg.mc  <= cfg_data[31:16];
          cfg.md  <= cfg_data[15:0];
        end
        bpc_pkg::REG_PLIN: begin
          cfg.ac1 <= cfg_data[63:48];
          cfg.ac2 <= cfg_data[47:32];
          cfg.ac3 <= cfg_data[31:16];
          cfg.ac4 <= cfg_data[15:0];
        end
        bpc_pkg::REG_PQUAD: begin
          cfg.b1 <= cfg_data[31:16];
          cfg.b2 <= cfg_data[15:0];
        end
        bpc_pkg::REG_OSS: begin
          cfg.oss <= cfg_data[1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: src/bpc_queue.sv
`timescale 1ns / 1ps
// Small FIFO between front end and compute pipeline.
// Depends on bpc_pkg.
module bpc_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bpc_pkg::bpc_sample_t push_data,
  input  logic                 pop,
  output bpc_pkg::bpc_sample_t pop_data,
  output logic                 full,
  output logic                 empty
);

  localparam int PtrBits = $clog2(bpc_pkg::QueueDepth);

  bpc_pkg::bpc_sample_t mem [bpc_pkg::QueueDepth];
  logic [PtrBits-1:0]   wr_ptr;
  logic [PtrBits-1:0]   rd_ptr;
  logic [PtrBits:0]     count;

  assign full     = count == (PtrBits+1)'(bpc_pkg::QueueDepth);
  assign empty    = count == '0;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: src/bpc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, unsigned, one quotient bit per stage.
// Depends on bpc_pkg.
module bpc_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [bpc_pkg::DivBits-1:0]   dividend,
  input  logic [bpc_pkg::DsrBits-1:0]   divisor,
  output logic [bpc_pkg::DivBits-1:0]   quotient
);

  localparam int N  = bpc_pkg::DivBits;
  localparam int DW = bpc_pkg::DsrBits;

  logic [DW-1:0] rem_q [N];
  logic [N-1:0]  dvd_q [N];
  logic [N-1:0]  quo_q [N];
  logic [DW-1:0] dsr_q [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_stage
      logic [DW-1:0] rem_in;
      logic [N-1:0]  dvd_in;
      logic [N-1:0]  quo_in;
      logic [DW-1:0] dsr_in;
      logic [DW:0]   sh;
      logic [DW:0]   diff;
      logic          fit;

      if (i == 0) begin : g_first
        assign rem_in = '0;
        assign dvd_in = dividend;
        assign quo_in = '0;
        assign dsr_in = divisor;
      end else begin : g_next
        assign rem_in = rem_q[i-1];
        assign dvd_in = dvd_q[i-1];
        assign quo_in = quo_q[i-1];
        assign dsr_in = dsr_q[i-1];
      end

      assign sh   = {rem_in, dvd_in[N-1]};
      assign diff = sh - {1'b0, dsr_in};
      assign fit  = sh >= {1'b0, dsr_in};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[i] <= fit ? diff[DW-1:0] : sh[DW-1:0];
          dvd_q[i] <= {dvd_in[N-2:0], 1'b0};
          quo_q[i] <= {quo_in[N-2:0], fit};
          dsr_q[i] <= dsr_in;
        end
      end
    end
  endgenerate

  assign quotient = quo_q[N-1];

endmodule

// File: src/bpc_back.sv
`timescale 1ns / 1ps
// Compute pipeline: temperature and pressure polynomials, two pipelined dividers,
// saturation and output register. Depends on bpc_pkg and bpc_div.
module bpc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bpc_pkg::bpc_cfg_t    cfg,
  input  logic                 queue_empty,
  input  bpc_pkg::bpc_sample_t pop_data,
  output logic                 pop,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic signed [15:0]   temperature,
  output logic [19:0]          pressure,
  output logic                 divide_error
);

  localparam int UB = bpc_pkg::UpBits;
  localparam int DS = bpc_pkg::DivStages;
  localparam int BL = bpc_pkg::BackLatency;

  typedef struct packed {
    logic signed [18:0] x1;
    logic               neg;
    logic               err;
    logic [UB-1:0]      up;
    logic signed [15:0] t;
    logic               big;
  } side_t;

  logic          adv;
  logic [BL-1:0] vld;

  assign result_valid = vld[BL-1];
  assign adv          = !result_valid || !result_stall;
  assign pop          = adv && !queue_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[BL-2:0], pop};
    end
  end

  // temperature front: x1 and divisor
  logic signed [17:0] a_d;
  logic [UB-1:0]      a_up;
  logic signed [34:0] b_prod;
  logic [UB-1:0]      b_up;
  logic signed [18:0] c_x1;
  logic signed [18:0] c_den;
  logic [UB-1:0]      c_up;
  logic [31:0]        d_dvd;
  logic [17:0]        d_dsr;
  side_t              d_sd;

  logic signed [18:0] c_x1_w;
  logic signed [18:0] neg_den_w;
  logic signed [16:0] mc_w;
  logic signed [16:0] neg_mc_w;
  logic [16:0]        mc_mag_w;

  assign c_x1_w    = 19'(b_prod >>> 15);
  assign neg_den_w = -c_den;
  assign mc_w      = {cfg.mc[15], cfg.mc};
  assign neg_mc_w  = -mc_w;
  assign mc_mag_w  = mc_w[16] ? neg_mc_w : mc_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      a_d    <= $signed({2'b00, pop_data.ut}) - $signed({2'b00, cfg.ac6});
      a_up   <= pop_data.up;
      b_prod <= a_d * $signed({1'b0, cfg.ac5});
      b_up   <= a_up;
      c_x1   <= c_x1_w;
      c_den  <= c_x1_w + $signed({{3{cfg.md[15]}}, cfg.md});
      c_up   <= b_up;
      d_dvd  <= {4'b0000, mc_mag_w, 11'b0};
      d_dsr  <= c_den[18] ? neg_den_w[17:0] : c_den[17:0];
      d_sd.x1  <= c_x1;
      d_sd.neg <= cfg.mc[15] ^ c_den[18];
      d_sd.err <= c_den == '0;
      d_sd.up  <= c_up;
      d_sd.t   <= '0;
      d_sd.big <= 1'b0;
    end
  end

  logic [31:0] q1;
  side_t       side1 [DS];

  bpc_div u_div_temp (
    .clk      (clk),
    .en       (adv),
    .dividend (d_dvd),
    .divisor  (d_dsr),
    .quotient (q1)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side1[0] <= d_sd;
      for (int k = 1; k < DS; k++) begin
        side1[k] <= side1[k-1];
      end
    end
  end

  // b5, temperature, pressure polynomial
  logic signed [27:0] e_b5;
  side_t              e_sd;
  logic signed [27:0] f_b6;
  side_t              f_sd;
  logic signed [55:0] g_sq;
  logic signed [43:0] g_a2;
  logic signed [43:0] g_a3;
  side_t              g_sd;
  logic signed [59:0] h_b2sq;
  logic signed [59:0] h_b1sq;
  logic signed [43:0] h_a2;
  logic signed [43:0] h_a3;
  side_t              h_sd;
  logic signed [51:0] i_x3a;
  logic signed [51:0] i_x3b;
  side_t              i_sd;
  logic [31:0]        j_b3;
  logic [31:0]        j_b4p;
  side_t              j_sd;
  logic [16:0]        k_b4;
  logic [31:0]        k_b7a;
  side_t              k_sd;
  logic [31:0]        l_b7;
  logic [16:0]        l_b4;
  side_t              l_sd;
  logic [31:0]        m_dvd;
  logic [17:0]        m_dsr;
  side_t              m_sd;

  logic signed [27:0] e_q_w;
  logic signed [27:0] e_x2_w;
  logic signed [27:0] f_t_w;
  logic signed [15:0] f_tsat_w;
  logic signed [43:0] h_sq_w;
  logic [35:0]        j_bs_w;
  logic [35:0]        j_sh_w;
  logic [31:0]        j_w;
  logic [47:0]        j_b4p_w;
  logic [47:0]        l_prod_w;
  logic [15:0]        l_scale_w;

  assign e_q_w  = $signed({1'b0, q1[26:0]});
  assign e_x2_w = side1[DS-1].neg ? -e_q_w : e_q_w;
  assign f_t_w  = (e_b5 + 28'sd8) >>> 4;

  always_comb begin
    if (f_t_w > 28'sd32767) begin
      f_tsat_w = 16'sh7FFF;
    end else if (f_t_w < -28'sd32768) begin
      f_tsat_w = -16'sh8000;
    end else begin
      f_tsat_w = f_t_w[15:0];
    end
  end

  assign h_sq_w    = 44'(g_sq >>> 12);
  assign j_bs_w    = 36'(i_x3a) + {{18{cfg.ac1[15]}}, cfg.ac1, 2'b00};
  assign j_sh_w    = (j_bs_w << cfg.oss) + 36'd2;
  assign j_w       = i_x3b[31:0] + 32'd32768;
  assign j_b4p_w   = cfg.ac4 * j_w;
  assign l_scale_w = bpc_pkg::PressScale >> cfg.oss;
  assign l_prod_w  = k_b7a * l_scale_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      e_b5   <= 28'(side1[DS-1].x1) + e_x2_w;
      e_sd   <= side1[DS-1];
      f_b6   <= e_b5 - bpc_pkg::TempOffset;
      f_sd   <= '{x1: e_sd.x1, neg: e_sd.neg, err: e_sd.err, up: e_sd.up,
                  t: f_tsat_w, big: e_sd.big};
      g_sq   <= f_b6 * f_b6;
      g_a2   <= cfg.ac2 * f_b6;
      g_a3   <= cfg.ac3 * f_b6;
      g_sd   <= f_sd;
      h_b2sq <= cfg.b2 * h_sq_w;
      h_b1sq <= cfg.b1 * h_sq_w;
      h_a2   <= g_a2;
      h_a3   <= g_a3;
      h_sd   <= g_sd;
      i_x3a  <= 52'(h_b2sq >>> 11) + 52'(h_a2 >>> 11);
      i_x3b  <= (52'(h_a3 >>> 13) + 52'(h_b1sq >>> 16) + 52'sd2) >>> 2;
      i_sd   <= h_sd;
      j_b3   <= j_sh_w[33:2];
      j_b4p  <= j_b4p_w[31:0];
      j_sd   <= i_sd;
      k_b4   <= j_b4p[31:15];
      k_b7a  <= {{(32-UB){1'b0}}, j_sd.up} - j_b3;
      k_sd   <= j_sd;
      l_b7   <= l_prod_w[31:0];
      l_b4   <= k_b4;
      l_sd   <= '{x1: k_sd.x1, neg: k_sd.neg, err: k_sd.err || (k_b4 == '0),
                  up: k_sd.up, t: k_sd.t, big: k_sd.big};
      m_dvd  <= l_b7[31] ? l_b7 : {l_b7[30:0], 1'b0};
      m_dsr  <= {1'b0, l_b4};
      m_sd   <= '{x1: l_sd.x1, neg: l_sd.neg, err: l_sd.err, up: l_sd.up,
                  t: l_sd.t, big: l_b7[31]};
    end
  end

  logic [31:0] q2;
  side_t       side2 [DS];

  bpc_div u_div_press (
    .clk      (clk),
    .en       (adv),
    .dividend (m_dvd),
    .divisor  (m_dsr),
    .quotient (q2)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side2[0] <= m_sd;
      for (int k = 1; k < DS; k++) begin
        side2[k] <= side2[k-1];
      end
    end
  end

  // final pressure correction
  logic [31:0]        n_pu;
  side_t              n_sd;
  logic [47:0]        o_sqp;
  logic signed [47:0] o_m7;
  logic [31:0]        o_pu;
  side_t              o_sd;
  logic [59:0]        p_x1c;
  logic signed [31:0] p_x2c;
  logic [31:0]        p_pu;
  side_t              p_sd;

  logic signed [47:0] q_s_w;
  logic signed [47:0] q_p_w;
  logic [19:0]        q_psat_w;

  assign q_s_w = $signed({4'b0000, p_x1c[59:16]}) + 48'(p_x2c) + bpc_pkg::PressConst;
  assign q_p_w = $signed({16'b0, p_pu}) + (q_s_w >>> 4);

  always_comb begin
    if (q_p_w < 48'sd0) begin
      q_psat_w = '0;
    end else if (q_p_w > 48'sd1048575) begin
      q_psat_w = bpc_pkg::PressMax;
    end else begin
      q_psat_w = q_p_w[19:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_pu  <= side2[DS-1].big ? {q2[30:0], 1'b0} : q2;
      n_sd  <= side2[DS-1];
      o_sqp <= n_pu[31:8] * n_pu[31:8];
      o_m7  <= bpc_pkg::PressLin * $signed({1'b0, n_pu});
      o_pu  <= n_pu;
      o_sd  <= n_sd;
      p_x1c <= o_sqp * bpc_pkg::PressQuad;
      p_x2c <= 32'(o_m7 >>> 16);
      p_pu  <= o_pu;
      p_sd  <= o_sd;
      divide_error <= p_sd.err;
      temperature  <= p_sd.err ? '0 : p_sd.t;
      pressure     <= p_sd.err ? '0 : q_psat_w;
    end
  end

endmodule

// File: src/barometric_pressure_compensation.sv
`timescale 1ns / 1ps
// Top level of the barometric pressure compensation block.
// Depends on bpc_pkg, bpc_front, bpc_queue, bpc_back.
//
//   channel  handshake                  payload
//   sample   sample_valid/sample_stall  raw_temperature, raw_pressure_bytes
//   result   result_valid/result_stall  temperature, pressure, divide_error
//   config   cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One item per cycle while no result stall holds the pipeline; the result is valid
// once the sample has passed the 4-entry queue and the back pipeline, whose depth
// is set by the two 32-stage pipelined dividers.
// rst is synchronous; it clears queue, valids and coefficients; oversampling goes to 3.
// A stalled result freezes the whole back pipeline; the queue keeps taking items
// until it holds 4.
module barometric_pressure_compensation (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  logic [15:0]        raw_temperature,
  input  logic [23:0]        raw_pressure_bytes,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [15:0] temperature,
  output logic [19:0]        pressure,
  output logic               divide_error,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  bpc_pkg::bpc_cfg_t    cfg;
  bpc_pkg::bpc_sample_t push_data;
  bpc_pkg::bpc_sample_t pop_data;
  logic                 push;
  logic                 pop;
  logic                 queue_full;
  logic                 queue_empty;

  bpc_front u_front (
    .clk                (clk),
    .rst                (rst),
    .sample_valid       (sample_valid),
    .sample_stall       (sample_stall),
    .raw_temperature    (raw_temperature),
    .raw_pressure_bytes (raw_pressure_bytes),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .cfg                (cfg),
    .push               (push),
    .push_data          (push_data),
    .queue_full         (queue_full)
  );

  bpc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (queue_full),
    .empty     (queue_empty)
  );

  bpc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_empty  (queue_empty),
    .pop_data     (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .temperature  (temperature),
    .pressure     (pressure),
    .divide_error (divide_error)
  );

endmodule

// File: src/bpc_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the compensation block, bound to the top level.
// Depends on barometric_pressure_compensation.
module bpc_chk (
  input logic               clk,
  input logic               rst,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic signed [15:0] temperature,
  input logic [19:0]        pressure,
  input logic               divide_error
);

  a_reset_no_result: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  a_reset_no_stall: assert property (@(posedge clk) rst |=> !sample_stall)
    else $error("sample stall right after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && divide_error |-> temperature == 16'sd0 && pressure == 20'd0)
    else $error("divide error with nonzero results");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(temperature) &&
      $stable(pressure) && $stable(divide_error))
    else $error("stalled result changed");

endmodule

bind barometric_pressure_compensation bpc_chk u_chk (.*);

// File: tb/sv/barometric_pressure_compensation_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for barometric_pressure_compensation: predicts each compensated
// temperature/pressure item from the calibration registers and compares it with the block.
// Depends on bpc_pkg and the block's RTL.
module barometric_pressure_compensation_tb;

  typedef struct packed {
    logic [15:0] ut;
    logic [23:0] bytes;
  } raw_item_t;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [19:0]        press;
    logic               derr;
  } comp_item_t;

  localparam int SettleCycles = 120;
  localparam longint CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [15:0] raw_temperature = '0;
  logic [23:0] raw_pressure_bytes = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [15:0] temperature;
  logic [19:0] pressure;
  logic divide_error;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  barometric_pressure_compensation u_dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .raw_temperature(raw_temperature), .raw_pressure_bytes(raw_pressure_bytes),
    .result_valid(result_valid), .result_stall(result_stall),
    .temperature(temperature), .pressure(pressure), .divide_error(divide_error),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic [63:0] temp_coef = '0;
  logic [63:0] plin_coef = '0;
  logic [31:0] pquad_coef = '0;
  logic [1:0]  oss_set = bpc_pkg::OssReset;

  raw_item_t  pending_samples[$];
  comp_item_t expected_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_derr = 0;
  int n_sat = 0;
  bit quiet_phase = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  longint cycles = 0;
  // holds the driver off sending new samples while set
  bit quiet_phase_hold = 1'b0;
  // sample item taken at the last rising edge
  bit in_taken = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint sext16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic comp_item_t compensate(raw_item_t s);
    comp_item_t r;
    longint ut, up, ac5, ac6, mc, md, ac1, ac2, ac3, ac4, b1, b2;
    longint x1, x2, x3, b3, b5, b6, sq, t, p;
    logic [31:0] b4, b7, pu;
    r.temp = '0;
    r.press = '0;
    r.derr = 1'b1;
    ut = longint'(s.ut);
    up = longint'(s.bytes >> (8 - oss_set));
    ac5 = longint'(temp_coef[63:48]);
    ac6 = longint'(temp_coef[47:32]);
    mc = sext16(temp_coef[31:16]);
    md = sext16(temp_coef[15:0]);
    ac1 = sext16(plin_coef[63:48]);
    ac2 = sext16(plin_coef[47:32]);
    ac3 = sext16(plin_coef[31:16]);
    ac4 = longint'(plin_coef[15:0]);
    b1 = sext16(pquad_coef[31:16]);
    b2 = sext16(pquad_coef[15:0]);
    x1 = floor_shr((ut - ac6) * ac5, 15);
    if (x1 + md == 0) return r;
    x2 = (mc * 2048) / (x1 + md);
    b5 = x1 + x2;
    t = floor_shr(b5 + 8, 4);
    b6 = b5 - 4000;
    sq = floor_shr(b6 * b6, 12);
    x1 = floor_shr(b2 * sq, 11);
    x2 = floor_shr(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = floor_shr((ac1 * 4 + x3) * (longint'(1) << oss_set) + 2, 2);
    x1 = floor_shr(ac3 * b6, 13);
    x2 = floor_shr(b1 * sq, 16);
    x3 = floor_shr(x1 + x2 + 2, 2);
    b4 = (32'(ac4) * 32'(x3 + 32768)) >> 15;
    if (b4 == 0) return r;
    b7 = 32'(up) - 32'(b3);
    b7 = b7 * (32'd50000 >> oss_set);
    if (b7 < 32'h8000_0000) pu = (b7 * 32'd2) / b4;
    else pu = (b7 / b4) * 32'd2;
    p = longint'(pu);
    x1 = (p >> 8) * (p >> 8);
    x1 = floor_shr(x1 * 3038, 16);
    x2 = floor_shr(-7357 * p, 16);
    p = p + floor_shr(x1 + x2 + 3791, 4);
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    if (p > 1048575) p = 1048575;
    if (p < 0) p = 0;
    r.temp = 16'(t);
    r.press = 20'(p);
    r.derr = 1'b0;
    return r;
  endfunction

  // driver
  always @(negedge clk) begin
    if (!rst) begin
      if (!sample_valid || in_taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() > 0 && !quiet_phase_hold) begin
          if (!quiet_phase && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(0, 18);
            sample_valid <= 1'b0;
          end else begin
            sample_valid <= 1'b1;
            raw_temperature <= pending_samples[0].ut;
            raw_pressure_bytes <= pending_samples[0].bytes;
          end
        end else begin
          sample_valid <= 1'b0;
        end
      end
      if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        result_stall <= 1'b1;
      end else if (!quiet_phase && $urandom_range(0, 15) == 0) begin
        recv_gap <= $urandom_range(0, 18);
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    comp_item_t got, want;
    cycles <= cycles + 1;
    in_taken = !rst && sample_valid && !sample_stall;
    if (!rst) begin
      if (sample_valid && !sample_stall) begin
        expected_results.push_back(compensate(pending_samples.pop_front()));
        n_sent <= n_sent + 1;
      end
      if (result_valid && !result_stall) begin
        got.temp = temperature;
        got.press = pressure;
        got.derr = divide_error;
        if (expected_results.size() == 0) begin
          $error("result item with nothing expected: temperature %0d pressure %0d",
                 got.temp, got.press);
          errors = errors + 1;
        end else begin
          want = expected_results.pop_front();
          n_checked <= n_checked + 1;
          if (want.derr) n_derr <= n_derr + 1;
          if (want.temp == 16'sh7FFF || want.temp == -16'sh8000 ||
              want.press == bpc_pkg::PressMax)
            n_sat <= n_sat + 1;
          if (got.temp !== want.temp) begin
            $error("temperature: expected %0d, actual %0d", want.temp, got.temp);
            errors = errors + 1;
          end
          if (got.press !== want.press) begin
            $error("pressure: expected %0d, actual %0d", want.press, got.press);
            errors = errors + 1;
          end
          if (got.derr !== want.derr) begin
            $error("divide_error: expected %0d, actual %0d", want.derr, got.derr);
            errors = errors + 1;
          end
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("barometric_pressure_compensation_tb failed");
      $finish;
    end
  end

  task automatic write_reg(bpc_pkg::bpc_reg_t idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bpc_pkg::REG_TEMP:  temp_coef = val;
      bpc_pkg::REG_PLIN:  plin_coef = val;
      bpc_pkg::REG_PQUAD: pquad_coef = val[31:0];
      bpc_pkg::REG_OSS:   oss_set = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || expected_results.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic load_typical(logic [1:0] oss);
    // typical calibration set from a real part
    write_reg(bpc_pkg::REG_TEMP, {16'd24875, 16'd17932, -16'sd11786, 16'sd2868});
    write_reg(bpc_pkg::REG_PLIN, {16'sd408, -16'sd72, -16'sd14383, 16'd32741});
    write_reg(bpc_pkg::REG_PQUAD, {32'd0, 16'sd6190, 16'sd4});
    write_reg(bpc_pkg::REG_OSS, 64'(oss));
  endtask

  function automatic raw_item_t rand_sample();
    raw_item_t s;
    s.ut = 16'($urandom);
    s.bytes = 24'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      s.ut = 16'($urandom_range(20000, 32000));
      s.bytes = 24'($urandom_range(24'h500000, 24'hB00000));
    end
    return s;
  endfunction

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) pending_samples.push_back(rand_sample());
    drain();
  endtask

  initial begin
    raw_item_t s;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset coefficients: zero divisor on the temperature path
    quiet_phase_hold = 1'b1;
    s.ut = 16'd27898; s.bytes = 24'h5D2300;
    pending_samples.push_back(s);
    quiet_phase_hold = 1'b0;
    drain();

    load_typical(2'd0);
    s.ut = 16'd27898; s.bytes = 24'h5D2300;   pending_samples.push_back(s);
    s.ut = 16'd0;     s.bytes = 24'h000000;   pending_samples.push_back(s);
    s.ut = 16'hFFFF;  s.bytes = 24'hFFFFFF;   pending_samples.push_back(s);
    s.ut = 16'hAAAA;  s.bytes = 24'h555555;   pending_samples.push_back(s);
    s.ut = 16'h5555;  s.bytes = 24'hAAAAAA;   pending_samples.push_back(s);
    s.ut = 16'd17932; s.bytes = 24'h800000;   pending_samples.push_back(s);
    drain();
    write_reg(bpc_pkg::REG_OSS, 64'd3);
    s.ut = 16'd27898; s.bytes = 24'h5D23FF;   pending_samples.push_back(s);
    s.ut = 16'hFFFF;  s.bytes = 24'h000000;   pending_samples.push_back(s);
    s.ut = 16'h0000;  s.bytes = 24'hFFFFFF;   pending_samples.push_back(s);
    drain();
    // pressure divisor zero: ac4 = 0
    write_reg(bpc_pkg::REG_PLIN, {16'sd408, -16'sd72, -16'sd14383, 16'd0});
    s.ut = 16'd27898; s.bytes = 24'h5D2300;   pending_samples.push_back(s);
    drain();
    // extreme coefficients drive saturation on both outputs
    write_reg(bpc_pkg::REG_TEMP, {16'hFFFF, 16'h0000, 16'h7FFF, 16'h0001});
    write_reg(bpc_pkg::REG_PLIN, {16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF});
    write_reg(bpc_pkg::REG_PQUAD, {32'd0, 16'h7FFF, 16'h8000});
    s.ut = 16'hFFFF;  s.bytes = 24'hFFFFFF;   pending_samples.push_back(s);
    s.ut = 16'h0000;  s.bytes = 24'h000000;   pending_samples.push_back(s);
    s.ut = 16'h8000;  s.bytes = 24'h123456;   pending_samples.push_back(s);
    drain();
    write_reg(bpc_pkg::REG_TEMP, {16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF});
    write_reg(bpc_pkg::REG_PQUAD, {32'hFFFF_FFFF, 16'h8000, 16'h7FFF});
    write_reg(bpc_pkg::REG_OSS, 64'd1);
    s.ut = 16'hFFFF;  s.bytes = 24'hFFFFFF;   pending_samples.push_back(s);
    s.ut = 16'h0000;  s.bytes = 24'h000001;   pending_samples.push_back(s);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      load_typical(2'(ph));
      random_phase(250);
    end
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(bpc_pkg::REG_TEMP, {$urandom, $urandom});
      write_reg(bpc_pkg::REG_PLIN, {$urandom, $urandom});
      write_reg(bpc_pkg::REG_PQUAD, {32'($urandom), 32'($urandom)});
      write_reg(bpc_pkg::REG_OSS, 64'($urandom_range(0, 3)));
      random_phase(200);
    end
    load_typical(2'd3);
    quiet_phase = 1'b1;
    random_phase(150);

    $display("checked %0d of %0d items: %0d divide errors, %0d saturated",
             n_checked, n_sent, n_derr, n_sat);
    if (errors == 0) begin
      $display("barometric_pressure_compensation_tb passed");
    end else begin
      $display("barometric_pressure_compensation_tb failed");
    end
    $finish;
  end

endmodule
